### rtl/core/ots_pkg.sv
// ============================================================================
// ots_pkg - odd-even transposition sorter package
// Shared key width, default capacity and the sequencer state type.
// ============================================================================
`default_nettype none

package ots_pkg;

    localparam int KEY_W         = 64;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_CMP,
        ST_WR2,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

`default_nettype wire

### rtl/core/ots_ram.sv
// ============================================================================
// ots_ram - generic RAM
// One write port, two read ports, registered read data, no reset.
// ============================================================================
`default_nettype none

module ots_ram #(
    parameter int WIDTH = ots_pkg::KEY_W,
    parameter int DEPTH = ots_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### rtl/core/odd_even_transposition_sorter_top.sv
// ============================================================================
// odd_even_transposition_sorter_top - odd-even transposition sorter
// Collects keys into a RAM, sorts them with one shared compare-exchange
// unit stepping over even and odd pairs, then streams them out ascending.
// ============================================================================
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata = key, tlast = is_final
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata = sorted_key,
//                                              tlast = end_of_run,
//                                              tuser = overflowed
//
//  Load: one cycle per key; s_axis_tready is high only while collecting.
//  Sort: one comparator; each pair is read and compared, and a swap writes
//  the lower key first; phases repeat until an even+odd pass swaps nothing
//  (at most n passes). Emit: each key goes through the output register
//  and waits there for m_axis_tready; a stalled result simply holds the sequencer.
//  Reset clears fill count, overflow flag and sequencer; the RAM is not
//  cleared since only entries written in the current set are ever read.
// ============================================================================
`default_nettype none

module odd_even_transposition_sorter_top #(
    parameter int DEPTH = ots_pkg::DEPTH_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [ots_pkg::KEY_W-1:0] s_axis_tdata,  // [63:0] key
    input  wire logic                      s_axis_tlast,  // is_final
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [ots_pkg::KEY_W-1:0] m_axis_tdata,  // [63:0] sorted_key
    output logic                           m_axis_tlast,  // end_of_run
    output logic                           m_axis_tuser   // [0] overflowed
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH + 2);

    ots_pkg::state_t state_reg, state_next;

    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          phase_reg, phase_next;
    logic          again_reg, again_next;
    logic [CW-1:0] emit_reg, emit_next;

    logic [ots_pkg::KEY_W-1:0] hold_reg, hold_next;
    logic [ots_pkg::KEY_W-1:0] out_key_reg, out_key_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [ots_pkg::KEY_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr_a;
    logic [AW-1:0]             ram_raddr_b;
    logic [ots_pkg::KEY_W-1:0] ram_rdata_a;
    logic [ots_pkg::KEY_W-1:0] ram_rdata_b;

    logic [IW:0]   idx_p1;
    logic [IW:0]   n_ext;
    logic          pair_ok;
    logic          full;
    logic          in_acc;
    logic [CW-1:0] emit_p1;

    assign idx_p1  = {1'b0, idx_reg} + (IW+1)'(1);
    assign n_ext   = (IW+1)'(fill_reg);
    assign pair_ok = (idx_p1 < n_ext);
    assign full    = (fill_reg == CW'(DEPTH));
    assign emit_p1 = emit_reg + CW'(1);

    assign s_axis_tready = (state_reg == ots_pkg::ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_key_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    ots_ram #(
        .WIDTH (ots_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ots_pkg::ST_LOAD;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            again_reg     <= 1'b0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            again_reg     <= again_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_key_reg  <= out_key_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        again_next     = again_reg;
        emit_next      = emit_reg;
        hold_next      = hold_reg;
        out_key_next   = out_key_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        ram_we      = 1'b0;
        ram_waddr   = fill_reg[AW-1:0];
        ram_wdata   = s_axis_tdata;
        ram_raddr_a = idx_reg[AW-1:0];
        ram_raddr_b = idx_p1[AW-1:0];

        case (state_reg)
            ots_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        idx_next   = '0;
                        phase_next = 1'b0;
                        again_next = 1'b0;
                        state_next = ots_pkg::ST_RD;
                    end
                end
            end

            ots_pkg::ST_RD:
            begin
                if (pair_ok)
                begin
                    state_next = ots_pkg::ST_CMP;
                end
                else if (!phase_reg)
                begin
                    // even phase done, start odd phase at pair (1,2)
                    phase_next = 1'b1;
                    idx_next   = IW'(1);
                end
                else if (again_reg)
                begin
                    phase_next = 1'b0;
                    idx_next   = '0;
                    again_next = 1'b0;
                end
                else
                begin
                    emit_next  = '0;
                    state_next = ots_pkg::ST_EMIT_RD;
                end
            end

            ots_pkg::ST_CMP:
            begin
                if (ram_rdata_a > ram_rdata_b)
                begin
                    // lower key goes left now, upper key next cycle
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg[AW-1:0];
                    ram_wdata  = ram_rdata_b;
                    hold_next  = ram_rdata_a;
                    again_next = 1'b1;
                    state_next = ots_pkg::ST_WR2;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(2);
                    state_next = ots_pkg::ST_RD;
                end
            end

            ots_pkg::ST_WR2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_p1[AW-1:0];
                ram_wdata  = hold_reg;
                idx_next   = idx_reg + IW'(2);
                state_next = ots_pkg::ST_RD;
            end

            ots_pkg::ST_EMIT_RD:
            begin
                ram_raddr_a = emit_reg[AW-1:0];
                state_next  = ots_pkg::ST_EMIT_LD;
            end

            ots_pkg::ST_EMIT_LD:
            begin
                out_key_next   = ram_rdata_a;
                out_last_next  = (emit_p1 == fill_reg);
                out_ovf_next   = ovf_reg;
                out_valid_next = 1'b1;
                state_next     = ots_pkg::ST_EMIT_WAIT;
            end

            ots_pkg::ST_EMIT_WAIT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    emit_next      = emit_p1;
                    if (out_last_reg)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ots_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = ots_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ots_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

### bench/tb_odd_even_transposition_sorter_top.sv
// ============================================================================
// tb_odd_even_transposition_sorter_top - sorter regression bench
// Streams sets of 64-bit keys into the sorter, predicts the ascending output
// of each set (end marker and overflow flag included) and checks every
// result item in order. Idle patterns, a long output stall and a drained
// pause exercise the handshakes on both sides.
// ============================================================================
module tb_odd_even_transposition_sorter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = ots_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 1000;
    localparam int ITEMS_PER_PHASE = 70;

    typedef logic [ots_pkg::KEY_W-1:0] key_t;

    typedef struct packed {
        key_t key;
        logic eor;
        logic ovf;
    } sorted_item_t;

    typedef struct {
        key_t         key;
        logic         fin;
        bit           pinned;
        sorted_item_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    key_t s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    key_t m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;

    // predictor state
    key_t        held_keys [STORE_DEPTH];
    int unsigned held_count = 0;
    bit          dropped = 1'b0;

    sorted_item_t sorted_q [$];
    stim_row_t    plan [$];

    int errors = 0;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int hold_left = 0;
    bit long_hold_req = 1'b0;

    odd_even_transposition_sorter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // store one key; on the final key sort the set and, if asked, queue its results
    function automatic void absorb_key(key_t key, logic fin, bit queue_it);
        key_t         t;
        bit           swapped;
        int           n;
        sorted_item_t r;
        if (held_count < STORE_DEPTH)
        begin
            held_keys[held_count] = key;
            held_count++;
        end
        else
            dropped = 1'b1;
        if (fin)
        begin
            n = held_count;
            do
            begin
                swapped = 1'b0;
                for (int p = 0; p < 2; p++)
                    for (int i = p; i + 1 < n; i += 2)
                        if (held_keys[i] > held_keys[i+1])
                        begin
                            t = held_keys[i];
                            held_keys[i] = held_keys[i+1];
                            held_keys[i+1] = t;
                            swapped = 1'b1;
                        end
            end
            while (swapped);
            if (queue_it)
                for (int k = 0; k < n; k++)
                begin
                    r.key = held_keys[k];
                    r.eor = (k + 1 == n);
                    r.ovf = dropped;
                    sorted_q.push_back(r);
                end
            held_count = 0;
            dropped = 1'b0;
        end
    endfunction

    // drive one key, wait for the handshake, predict, then maybe idle
    task automatic offer_key(key_t key, logic fin, bit pinned, sorted_item_t want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        absorb_key(key, fin, !pinned);
        if (pinned)
            sorted_q.push_back(want);
        if ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sorted_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic send_random_set(input int forced_len, output int len);
        int   pick;
        int   mode;
        key_t k;
        pick = $urandom_range(0, 19);
        if (forced_len > 0)
            len = forced_len;
        else if (pick < 12)
            len = $urandom_range(1, 8);
        else if (pick < 16)
            len = $urandom_range(9, 16);
        else if (pick < 18)
            len = STORE_DEPTH;
        else
            len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 5);
        mode = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: k = {$urandom, $urandom};
                1: k = key_t'($urandom_range(0, 7));    // many duplicates
                2: case ($urandom_range(0, 3))
                       0: k = '0;
                       1: k = '1;
                       2: k = key_t'(1);
                       default: k = ~key_t'(1);
                   endcase
                default: k = {2'($urandom_range(0, 3)), 30'd0, $urandom};
            endcase
            offer_key(k, i == len - 1, 1'b0, '0);
        end
    endtask

    // result side: random back-pressure plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        sorted_item_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sorted_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, expected none actual key %h last %b ovf %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            else
            begin
                e = sorted_q.pop_front();
                if (m_axis_tdata !== e.key)
                begin
                    errors++;
                    $display("%0t: sorted_key expected %h actual %h",
                             $time, e.key, m_axis_tdata);
                end
                if (m_axis_tlast !== e.eor)
                begin
                    errors++;
                    $display("%0t: end_of_run expected %b actual %b",
                             $time, e.eor, m_axis_tlast);
                end
                if (m_axis_tuser !== e.ovf)
                begin
                    errors++;
                    $display("%0t: overflowed expected %b actual %b",
                             $time, e.ovf, m_axis_tuser);
                end
            end
        end
    end

    function automatic void add_row(key_t key, logic fin, bit pinned, sorted_item_t want);
        stim_row_t row;
        row.key = key;
        row.fin = fin;
        row.pinned = pinned;
        row.want = want;
        plan.push_back(row);
    endfunction

    initial
    begin
        int len;
        int sent;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-key sets at the extremes
        add_row('0, 1'b1, 1'b1, '{key: '0, eor: 1'b1, ovf: 1'b0});
        add_row('1, 1'b1, 1'b1, '{key: '1, eor: 1'b1, ovf: 1'b0});
        // equal keys with a smaller one between them
        add_row(64'h8000_0000_0000_0000, 1'b0, 1'b0, '0);
        add_row('0, 1'b0, 1'b0, '0);
        add_row(64'h8000_0000_0000_0000, 1'b1, 1'b0, '0);
        // descending full store; the final key finds it full and is dropped
        for (int i = 0; i < STORE_DEPTH + 1; i++)
            add_row(key_t'(64'hFFFF_FFFF_FFFF_FF00 - i * 3), i == STORE_DEPTH, 1'b0, '0);
        // overflow flag must be gone in the next set
        add_row(key_t'(1), 1'b1, 1'b1, '{key: key_t'(1), eor: 1'b1, ovf: 1'b0});

        send_gap_pct = 35;
        recv_gap_pct = 83;
        foreach (plan[i])
            offer_key(plan[i].key, plan[i].fin, plan[i].pinned, plan[i].want);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct = 35;
                    recv_gap_pct = 83;
                end
                1:
                begin
                    send_gap_pct = 83;
                    recv_gap_pct = 35;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            sent = 0;
            if (ph == 2)
            begin
                // stall the output for a long time while input keeps coming
                long_hold_req = 1'b1;
                send_random_set(4, len);
                sent += len;
            end
            while (sent < ITEMS_PER_PHASE)
            begin
                send_random_set(0, len);
                sent += len;
            end
            drain();
        end

        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
